// File: hdl/dml_pkg.sv
// ----------------------------------------------------------------------------
// dml_pkg
// Shared types and constants for the decimal long multiplier.
// ----------------------------------------------------------------------------
package dml_pkg;

    localparam int FACTOR_W   = 31;  // binary factor width
    localparam int OUT_DIGITS = 10;  // BCD digits per result half
    localparam int BCD_W      = 4 * OUT_DIGITS;

    typedef struct packed {
        logic [FACTOR_W-1:0] multiplicand;
        logic [FACTOR_W-1:0] multiplier;
    } t_operands;

    typedef struct packed {
        logic [BCD_W-1:0] product_low_bcd;
        logic [BCD_W-1:0] product_high_bcd;
    } t_product;

    // converter control from the sequencer
    typedef struct packed {
        logic load;   // take a new binary value, clear digits
        logic shift;  // one double-dabble step
    } t_b2d_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_MUL,
        ST_DONE
    } t_state;

endpackage

// File: hdl/dml_b2d.sv
// ----------------------------------------------------------------------------
// dml_b2d
// Bit-serial binary to BCD converter (shift, add-3), one bit per cycle on shift.
// ----------------------------------------------------------------------------
module dml_b2d #(
    parameter int DIGITS = 10
) (
    input  logic                          i_clk,
    input  dml_pkg::t_b2d_ctl             i_ctl,
    input  logic [dml_pkg::FACTOR_W-1:0]  i_value,
    output logic [DIGITS-1:0][3:0]        o_digits
);

    logic [dml_pkg::FACTOR_W-1:0] r_value;
    logic [DIGITS-1:0][3:0]       r_digits;
    logic [DIGITS-1:0][3:0]       n_adj;
    logic [4*DIGITS:0]            n_shift;  // adjusted digits doubled, next bit in

    // add 3 to every digit of 5 or more before the doubling
    always_comb begin
        for (int k = 0; k < DIGITS; k++) begin
            n_adj[k] = (r_digits[k] >= 4'd5) ? r_digits[k] + 4'd3 : r_digits[k];
        end
    end

    assign n_shift = {n_adj, r_value[dml_pkg::FACTOR_W-1]};

    // digit carried out of the top column is dropped: value mod 10^DIGITS
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_value  <= i_value;
            r_digits <= '0;
        end else if (i_ctl.shift) begin
            r_value  <= {r_value[dml_pkg::FACTOR_W-2:0], 1'b0};
            r_digits <= n_shift[4*DIGITS-1:0];
        end
    end

    assign o_digits = r_digits;

endmodule

// File: hdl/dml_mac.sv
// ----------------------------------------------------------------------------
// dml_mac
// Decimal digit multiply-add: a*b + sum + carry, split into digit and carry.
// ----------------------------------------------------------------------------
module dml_mac (
    input  logic [3:0] i_a,
    input  logic [3:0] i_b,
    input  logic [3:0] i_sum,
    input  logic [3:0] i_carry,
    output logic [3:0] o_digit,
    output logic [3:0] o_carry
);

    logic [6:0]  t;      // at most 99
    logic [13:0] recip;
    logic [3:0]  q;
    logic [6:0]  rem;

    // t / 10 as (t * 103) >> 10, exact for t below 100
    always_comb begin
        t       = 7'(i_a) * 7'(i_b) + 7'(i_sum) + 7'(i_carry);
        recip   = 14'(t) * 14'd103;
        q       = recip[13:10];
        rem     = t - 7'(q) * 7'd10;
        o_digit = rem[3:0];
        o_carry = q;
    end

endmodule

// File: hdl/decimal_long_multiplier_core.sv
// ----------------------------------------------------------------------------
// decimal_long_multiplier_core
// BCD schoolbook multiplier: two binary factors are converted to decimal
// digits, then one shared digit multiply-add unit builds the product.
// ----------------------------------------------------------------------------
//
//  channel   | ports                        | handshake
//  ----------+------------------------------+-------------------------------
//  operands  | i_operands (t_operands)      | taken when start && !busy
//  product   | o_product  (t_product)       | one-cycle strobe o_done
//
//  Sequence: after accept, 31 double-dabble steps run both converters side
//  by side, then the single digit multiply-add unit visits each multiplier
//  row for DIGITS+1 columns, and then o_done is strobed. busy is low again
//  the cycle after the strobe. Reset returns the sequencer to idle; digit
//  storage is not cleared. The receiver cannot stall: o_done is shown once.
// ----------------------------------------------------------------------------
module decimal_long_multiplier_core #(
    parameter int DIGITS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  dml_pkg::t_operands i_operands,
    output logic               o_done,
    output dml_pkg::t_product  o_product
);

    localparam int IW  = $clog2(DIGITS + 1);  // column counter, 0..DIGITS
    localparam int AW  = $clog2(DIGITS);      // factor digit index
    localparam int SW  = $clog2(2 * DIGITS);  // running sum index
    localparam int BW  = $clog2(dml_pkg::FACTOR_W);
    localparam int SUM_DIGITS = 2 * DIGITS;
    localparam int ALL_OUT    = 2 * dml_pkg::OUT_DIGITS;

    dml_pkg::t_state   r_state, n_state;
    logic [BW-1:0]     r_bit,   n_bit;    // conversion step
    logic [IW-1:0]     r_i,     n_i;      // multiplicand column
    logic [AW-1:0]     r_j,     n_j;      // multiplier row

    logic [SUM_DIGITS-1:0][3:0] r_sum;
    logic [3:0]                 r_carry;

    dml_pkg::t_b2d_ctl      b2d_ctl;
    logic [DIGITS-1:0][3:0] a_digits;
    logic [DIGITS-1:0][3:0] b_digits;

    logic          accept;
    logic          last_col;
    logic [SW-1:0] sum_idx;
    logic [3:0]    mac_a;
    logic [3:0]    mac_cin;
    logic [3:0]    mac_digit;
    logic [3:0]    mac_cout;

    assign accept   = start && !busy;
    assign last_col = (r_i == IW'(DIGITS));
    assign sum_idx  = SW'(r_j) + SW'(r_i);

    // ---------------- converters: both factors in parallel ----------------
    assign b2d_ctl.load  = accept;
    assign b2d_ctl.shift = (r_state == dml_pkg::ST_CONV);

    dml_b2d #(.DIGITS(DIGITS)) u_b2d_a (
        .i_clk    (i_clk),
        .i_ctl    (b2d_ctl),
        .i_value  (i_operands.multiplicand),
        .o_digits (a_digits)
    );

    dml_b2d #(.DIGITS(DIGITS)) u_b2d_b (
        .i_clk    (i_clk),
        .i_ctl    (b2d_ctl),
        .i_value  (i_operands.multiplier),
        .o_digits (b_digits)
    );

    // ---------------- shared digit multiply-add ----------------
    // Column DIGITS of a row only places the row carry; its sum digit is
    // still zero at that point, since earlier rows cannot reach it.
    assign mac_a   = last_col ? 4'd0 : a_digits[r_i[AW-1:0]];
    assign mac_cin = (r_i == '0) ? 4'd0 : r_carry;

    dml_mac u_mac (
        .i_a     (mac_a),
        .i_b     (b_digits[r_j]),
        .i_sum   (r_sum[sum_idx]),
        .i_carry (mac_cin),
        .o_digit (mac_digit),
        .o_carry (mac_cout)
    );

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dml_pkg::ST_IDLE;
            r_bit   <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    always_comb begin
        n_state = r_state;
        n_bit   = r_bit;
        n_i     = r_i;
        n_j     = r_j;
        unique case (r_state)
            dml_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = dml_pkg::ST_CONV;
                    n_bit   = '0;
                end
            end
            dml_pkg::ST_CONV: begin
                n_bit = r_bit + 1'b1;
                if (r_bit == BW'(dml_pkg::FACTOR_W - 1)) begin
                    n_state = dml_pkg::ST_MUL;
                    n_i     = '0;
                    n_j     = '0;
                end
            end
            dml_pkg::ST_MUL: begin
                if (last_col) begin
                    n_i = '0;
                    if (r_j == AW'(DIGITS - 1)) begin
                        n_state = dml_pkg::ST_DONE;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            dml_pkg::ST_DONE: begin
                n_state = dml_pkg::ST_IDLE;
            end
            default: begin
                n_state = dml_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- running sum ----------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sum <= '0;
        end else if (r_state == dml_pkg::ST_MUL) begin
            r_sum[sum_idx] <= mac_digit;
            r_carry        <= mac_cout;
        end
    end

    // ---------------- result ----------------
    logic [ALL_OUT-1:0][3:0] out_digits;

    for (genvar k = 0; k < ALL_OUT; k++) begin : g_out
        if (k < SUM_DIGITS) begin : g_live
            assign out_digits[k] = r_sum[k];
        end else begin : g_zero
            assign out_digits[k] = 4'd0;
        end
    end

    assign o_product.product_low_bcd  = out_digits[dml_pkg::OUT_DIGITS-1:0];
    assign o_product.product_high_bcd = out_digits[ALL_OUT-1:dml_pkg::OUT_DIGITS];

    assign busy   = (r_state != dml_pkg::ST_IDLE);
    assign o_done = (r_state == dml_pkg::ST_DONE);

    // ---------------- assertions ----------------
    a_done_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy && (r_state == dml_pkg::ST_CONV))
        else $error("accepted word did not start conversion");

    a_carry_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dml_pkg::ST_MUL) && (r_i != '0) |-> (r_carry <= 4'd9))
        else $error("row carry out of decimal range");

    a_done_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == dml_pkg::ST_MUL)
        else $error("result shown without finishing the rows");

endmodule

// File: verif/tb_decimal_long_multiplier_core.sv
// ----------------------------------------------------------------------------
// tb_decimal_long_multiplier_core
// Self-checking bench for the BCD schoolbook multiplier: drives operand words
// (directed extremes, shaped random, then back-to-back), predicts each 20-digit
// BCD product and checks every strobed product word against it in order.
// ----------------------------------------------------------------------------
module tb_decimal_long_multiplier_core;

    typedef logic [dml_pkg::FACTOR_W-1:0] t_factor;

    localparam t_factor FACTOR_MAX = {dml_pkg::FACTOR_W{1'b1}};
    localparam int FACTOR_TOP   = int'(FACTOR_MAX);
    localparam int PROD_DIGITS  = 2 * dml_pkg::OUT_DIGITS;
    localparam int SETTLE_WAIT  = 160;        // outlasts one word from accept to strobe
    localparam int CYCLE_LIMIT  = 1_000_000;  // above the length of a slow run

    // shapes of random factors
    typedef enum logic [2:0] {
        SHAPE_WIDE,      // any 31-bit value
        SHAPE_SMALL,     // one or two digits
        SHAPE_NINES,     // mostly nines, long decimal carries
        SHAPE_POW10,     // one nonzero digit at a random position
        SHAPE_UNIT,      // zero or one
        SHAPE_NEAR_MAX   // at or just below the top of the range
    } t_shape;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    dml_pkg::t_operands i_operands;
    logic               o_done;
    dml_pkg::t_product  o_product;

    dml_pkg::t_product  pending_products[$];
    dml_pkg::t_product  oldest_product;
    int                 error_count;
    int                 cycle_count;

    decimal_long_multiplier_core #(
        .DIGITS(dml_pkg::OUT_DIGITS)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_operands(i_operands),
        .o_done    (o_done),
        .o_product (o_product)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // true product of the two factors, as 20 BCD digits split in two halves
    function automatic dml_pkg::t_product bcd_product_of(t_factor a, t_factor b);
        logic [63:0]              value;
        logic [4*PROD_DIGITS-1:0] digits;
        dml_pkg::t_product        product;
        value  = 64'(a) * 64'(b);
        digits = '0;
        for (int k = 0; k < PROD_DIGITS; k++) begin
            digits[4*k +: 4] = 4'(value % 64'd10);
            value            = value / 64'd10;
        end
        product.product_low_bcd  = digits[dml_pkg::BCD_W-1:0];
        product.product_high_bcd = digits[2*dml_pkg::BCD_W-1:dml_pkg::BCD_W];
        return product;
    endfunction

    function automatic t_factor shaped_factor();
        t_shape      shape;
        logic [31:0] value;
        int          digit;
        shape = ($urandom_range(0, 2) == 0) ? SHAPE_WIDE : t_shape'($urandom_range(0, 5));
        case (shape)
            SHAPE_SMALL: begin
                value = $urandom_range(0, 99);
            end
            SHAPE_NINES: begin
                // top digit 0 or 1 keeps ten digits under 2^31
                value = $urandom_range(0, 1);
                for (int k = 0; k < dml_pkg::OUT_DIGITS - 1; k++) begin
                    digit = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : 9;
                    value = value * 10 + digit;
                end
            end
            SHAPE_POW10: begin
                value = $urandom_range(1, 9);
                repeat ($urandom_range(0, 8)) value = value * 10;
            end
            SHAPE_UNIT: begin
                value = $urandom_range(0, 1);
            end
            SHAPE_NEAR_MAX: begin
                value = 32'(FACTOR_MAX) - $urandom_range(0, 15);
            end
            default: begin
                value = $urandom();
            end
        endcase
        return value[dml_pkg::FACTOR_W-1:0];
    endfunction

    // present one operand word and hold it until the core takes it
    task automatic send_operands(input t_factor a, input t_factor b);
        dml_pkg::t_product predicted;
        predicted = bcd_product_of(a, b);
        @(negedge i_clk);
        start                   = 1'b1;
        i_operands.multiplicand = a;
        i_operands.multiplier   = b;
        // busy only moves on a rising edge, so its value here holds to the next one
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        pending_products.push_back(predicted);
    endtask

    // drop start for a gap of length n, with junk on the operand bus
    task automatic hold_off(input int n);
        logic [63:0] junk;
        junk = {$urandom(), $urandom()};
        @(negedge i_clk);
        start      = 1'b0;
        i_operands = junk[$bits(dml_pkg::t_operands)-1:0];
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic test_directed_extremes();
        int lhs[16];
        int rhs[16];
        lhs = '{0, 0, FACTOR_TOP, FACTOR_TOP, 1, FACTOR_TOP, 1, 9,
                1999999999, 999999999, 1000000000, FACTOR_TOP, 1,
                1234567890, 1111111111, 2000000000};
        rhs = '{0, FACTOR_TOP, 0, FACTOR_TOP, FACTOR_TOP, 1, 1, 9,
                1999999999, 999999999, 1000000000, 1000000000, 0,
                987654321, 1111111111, 2000000000};
        for (int i = 0; i < 16; i++) begin
            send_operands(t_factor'(lhs[i]), t_factor'(rhs[i]));
            if (i % 2 == 1) hold_off($urandom_range(1, 14));
        end
    endtask

    task automatic test_random_operands(input int count);
        bit idling;
        idling = 1'b1;
        for (int i = 0; i < count; i++) begin
            // stretches with and without sender gaps
            if (i % 60 == 0) idling = ($urandom_range(0, 3) != 0);
            send_operands(shaped_factor(), shaped_factor());
            if (idling && $urandom_range(0, 2) == 0) hold_off($urandom_range(1, 14));
        end
    endtask

    task automatic test_back_to_back(input int count);
        for (int i = 0; i < count; i++) send_operands(shaped_factor(), shaped_factor());
    endtask

    // product checker: every strobe must match the oldest pending word
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_products.size() == 0) begin
                error_count++;
                $display("%0t: product word with none pending: low=%h high=%h",
                         $time, o_product.product_low_bcd, o_product.product_high_bcd);
            end else begin
                oldest_product = pending_products.pop_front();
                if (o_product.product_low_bcd !== oldest_product.product_low_bcd) begin
                    error_count++;
                    $display("%0t: product_low_bcd expected %h actual %h", $time,
                             oldest_product.product_low_bcd, o_product.product_low_bcd);
                end
                if (o_product.product_high_bcd !== oldest_product.product_high_bcd) begin
                    error_count++;
                    $display("%0t: product_high_bcd expected %h actual %h", $time,
                             oldest_product.product_high_bcd, o_product.product_high_bcd);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d products pending", $time, pending_products.size());
            $display("** decimal_long_multiplier_core: FAILED **");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        cycle_count = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_operands  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_extremes();
        test_random_operands(1000);
        test_back_to_back(134);

        @(negedge i_clk);
        start = 1'b0;
        while (pending_products.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);

        if (error_count == 0) begin
            $display("** decimal_long_multiplier_core: PASSED **");
        end else begin
            $display("** decimal_long_multiplier_core: FAILED **");
        end
        $finish;
    end

endmodule

// File: decimal_long_multiplier_core.f
hdl/dml_pkg.sv
hdl/dml_b2d.sv
hdl/dml_mac.sv
hdl/decimal_long_multiplier_core.sv
verif/tb_decimal_long_multiplier_core.sv
